// ----- hw/rtl/msb_first_bit_packer_defines.svh -----
// Assertion macros used by the bit packer back end.
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define MSBBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit packer check failed");

// Check a consequent in the cycle after its antecedent.
`define MSBBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit packer check failed");

`endif

// ----- hw/rtl/msbbp_pkg.sv -----
// Shared types and constants of the MSB-first bit packer.
package msbbp_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int LENGTH_BITS = 6;
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                   close;
        logic [VALUE_BITS-1:0]  value;
        logic [LENGTH_BITS-1:0] length;
    } item_t;

endpackage

// ----- hw/rtl/msb_first_bit_packer.sv -----
// A completed word reaches m_tvalid through the two-entry queue and then the output register.
// Throughput: one input word per cycle unless m_tready stalls the output register and the queue fills.
// A close on an empty buffer and a zero-length put produce no output word.
// Reset (rst_n low, asynchronous) empties the queue, clears the word buffer,
// the fill count and the output valid.
module msb_first_bit_packer #(
    parameter int WORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [msbbp_pkg::IN_DATA_BITS-1:0]    s_tdata,   // field_value[31:0], field_length[37:32], zero pad
    input  logic                                  s_tuser,   // cmd
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [msbbp_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // packed_word[31:0]
    output logic                                  m_tuser    // is_flush
);
    import msbbp_pkg::*;

    logic  queue_ready;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  pop_valid;
    item_t pop_item;

    msbbp_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cmd         (s_tuser),
        .field_value (s_tdata[VALUE_BITS-1:0]),
        .field_length(s_tdata[VALUE_BITS+LENGTH_BITS-1:VALUE_BITS]),
        .queue_ready (queue_ready),
        .push        (push),
        .item        (push_item)
    );

    msbbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .push_ready(queue_ready),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    msbbp_back #(
        .WORD_BITS(WORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item       (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .packed_word(m_tdata),
        .is_flush   (m_tuser)
    );

endmodule

// ----- hw/rtl/msbbp_front.sv -----
// Front end: accept words, saturate length, mask value, drop empty puts.
module msbbp_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic                                  cmd,
    input  logic [msbbp_pkg::VALUE_BITS-1:0]      field_value,
    input  logic [msbbp_pkg::LENGTH_BITS-1:0]     field_length,
    input  logic                                  queue_ready,
    output logic                                  push,
    output msbbp_pkg::item_t                      item
);
    import msbbp_pkg::*;

    localparam int LIMIT = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;

    logic [LENGTH_BITS-1:0] len_sat;
    logic [VALUE_BITS-1:0]  value_mask;
    logic                   keep;

    always_comb
    begin
        len_sat    = (field_length > LENGTH_BITS'(LIMIT)) ? LENGTH_BITS'(LIMIT) : field_length;
        value_mask = ~({VALUE_BITS{1'b1}} << len_sat);
        keep       = cmd || (len_sat != '0);
        item.close  = cmd;
        item.value  = field_value & value_mask;
        item.length = len_sat;
    end

    assign s_tready = queue_ready;
    assign push     = s_tvalid && queue_ready && keep;

endmodule

// ----- hw/rtl/msbbp_queue.sv -----
// Short queue between the front end and the packing back end.
module msbbp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  msbbp_pkg::item_t push_item,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output msbbp_pkg::item_t pop_item
);
    import msbbp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/msbbp_back.sv -----
// Back end: barrel-shift fields into the word buffer and register output words.
module msbbp_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    input  msbbp_pkg::item_t                      item,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [msbbp_pkg::OUT_DATA_BITS-1:0]   packed_word,
    output logic                                  is_flush
);
    import msbbp_pkg::*;

    `include "msb_first_bit_packer_defines.svh"

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * WORD_BITS;
    localparam int FW = $clog2(WORD_BITS);
    localparam int TW = FW + 1;
    localparam int SW = $clog2(2 * WORD_BITS + 1);

    logic [W-1:0]   word_buffer_reg, word_buffer_next;
    logic [FW-1:0]  fill_count_reg, fill_count_next;
    logic           out_valid_reg, out_valid_next;
    logic [OUT_DATA_BITS-1:0] out_word_reg, out_word_next;
    logic           out_flush_reg, out_flush_next;

    logic [TW-1:0]  total;
    logic [SW-1:0]  shamt;
    logic [DW-1:0]  val_wide;
    logic [DW-1:0]  combined;
    logic           fits;
    logic [W-1:0]   low_mask;

    assign pop = item_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        total    = TW'(fill_count_reg) + TW'(item.length);
        shamt    = SW'(DW) - SW'(total);
        val_wide = DW'(item.value);
        combined = {word_buffer_reg, {W{1'b0}}} | (val_wide << shamt);
        fits     = (total < TW'(W));
        low_mask = {W{1'b1}} >> fill_count_reg;

        word_buffer_next = word_buffer_reg;
        fill_count_next  = fill_count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_word_next    = out_word_reg;
        out_flush_next   = out_flush_reg;

        if (pop)
        begin
            if (item.close)
            begin
                if (fill_count_reg != '0)
                begin
                    out_valid_next   = 1'b1;
                    out_word_next    = OUT_DATA_BITS'(64'(word_buffer_reg));
                    out_flush_next   = 1'b1;
                    word_buffer_next = '0;
                    fill_count_next  = '0;
                end
            end
            else if (fits)
            begin
                word_buffer_next = combined[DW-1:W];
                fill_count_next  = FW'(total);
            end
            else
            begin
                out_valid_next   = 1'b1;
                out_word_next    = OUT_DATA_BITS'(64'(combined[DW-1:W]));
                out_flush_next   = 1'b0;
                word_buffer_next = combined[W-1:0];
                fill_count_next  = FW'(total - TW'(W));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_buffer_reg <= '0;
            fill_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            word_buffer_reg <= word_buffer_next;
            fill_count_reg  <= fill_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        out_flush_reg <= out_flush_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign packed_word = out_word_reg;
    assign is_flush    = out_flush_reg;

    `MSBBP_ASSERT_SAME(a_unused_bits_zero, clk, rst_n, 1'b1, (word_buffer_reg & low_mask) == '0)
    `MSBBP_ASSERT_NEXT(a_close_flushes, clk, rst_n, pop && item.close && (fill_count_reg != '0), out_valid_reg && out_flush_reg && (fill_count_reg == '0))
    `MSBBP_ASSERT_NEXT(a_partial_put_quiet, clk, rst_n, pop && !item.close && fits, (fill_count_reg == $past(FW'(total))) && (out_valid_reg == $past(out_valid_reg && !m_tready)))

endmodule

// ----- tb/msb_first_bit_packer_test.sv -----
// Self-checking testbench for the MSB-first bit packer: directed and random field streams.
module msb_first_bit_packer_test;

    import msbbp_pkg::*;

    localparam int PACK_WORD_BITS   = 32;
    localparam int MAX_FIELD_BITS   = 32;
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 11;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 12;
    localparam longint RUN_LIMIT    = 64'd12_000_000;

    typedef enum bit
    {
        CMD_PUT   = 1'b0,
        CMD_CLOSE = 1'b1
    } cmd_e;

    typedef struct
    {
        logic [OUT_DATA_BITS-1:0] word;
        logic                     flush;
    } packed_result_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic                     s_tuser  = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;

    logic [PACK_WORD_BITS-1:0] word_buf  = '0;
    int                        fill_bits = 0;
    packed_result_t            pending_words[$];

    int error_count   = 0;
    int words_sent    = 0;
    int closes_sent   = 0;
    int words_checked = 0;
    int flush_words   = 0;

    int hold_off_request     = 0;
    int hold_requests_served = 0;
    int hold_left            = 0;
    int run_left             = 0;
    bit run_free             = 1'b0;

    msb_first_bit_packer #(
        .WORD_BITS(PACK_WORD_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_HALF) clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic predict_packed_word(input cmd_e cmd, input logic [31:0] value,
                                       input logic [5:0] length);
        logic [63:0]    field;
        int             len;
        int             total;
        int             rem;
        packed_result_t res;
        if (cmd == CMD_CLOSE)
        begin
            if (fill_bits != 0)
            begin
                res.word  = word_buf;
                res.flush = 1'b1;
                pending_words.push_back(res);
                word_buf  = '0;
                fill_bits = 0;
            end
            return;
        end
        len = (length > MAX_FIELD_BITS) ? MAX_FIELD_BITS : length;
        if (len == 0)
            return;
        field = {32'b0, value} & ((64'd1 << len) - 64'd1);
        total = fill_bits + len;
        if (total < PACK_WORD_BITS)
        begin
            word_buf  = word_buf | PACK_WORD_BITS'(field << (PACK_WORD_BITS - total));
            fill_bits = total;
        end
        else
        begin
            rem       = total - PACK_WORD_BITS;
            res.word  = word_buf | PACK_WORD_BITS'(field >> rem);
            res.flush = 1'b0;
            pending_words.push_back(res);
            word_buf  = (rem == 0) ? '0 : PACK_WORD_BITS'(field << (PACK_WORD_BITS - rem));
            fill_bits = rem;
        end
    endtask

    task automatic send_word(input cmd_e cmd, input logic [31:0] value, input logic [5:0] length);
        logic [IN_DATA_BITS-1:0] packed_in;
        packed_in        = '0;
        packed_in[31:0]  = value;
        packed_in[37:32] = length;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= packed_in;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_packed_word(cmd, value, length);
        words_sent++;
        if (cmd == CMD_CLOSE)
            closes_sent++;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_for_drain();
        idle_cycles(1);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_item(input int close_pct);
        cmd_e        cmd;
        logic [31:0] value;
        logic [5:0]  length;
        int          pick;
        cmd  = ($urandom_range(0, 99) < close_pct) ? CMD_CLOSE : CMD_PUT;
        pick = $urandom_range(0, 9);
        value = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            length = 6'd0;
        else if (pick < 10)
            length = 6'($urandom_range(33, 63));
        else if (pick < 20)
            length = 6'd32;
        else
            length = 6'($urandom_range(1, 31));
        send_word(cmd, value, length);
    endtask

    task automatic test_directed_cases();
        send_word(CMD_CLOSE, 32'hFFFF_FFFF, 6'd63);
        send_word(CMD_PUT,   32'hFFFF_FFFF, 6'd0);
        send_word(CMD_PUT,   32'hDEAD_BEEF, 6'd32);
        send_word(CMD_PUT,   32'h1234_5678, 6'd63);
        send_word(CMD_PUT,   32'hFFFF_FFFF, 6'd33);
        send_word(CMD_PUT,   32'hFFFF_FFFF, 6'd1);
        send_word(CMD_PUT,   32'h0000_0000, 6'd32);
        send_word(CMD_CLOSE, 32'hFFFF_FFFF, 6'd40);
        send_word(CMD_PUT,   32'h7FFF_FFFF, 6'd31);
        send_word(CMD_PUT,   32'hFFFF_FFFF, 6'd1);
        send_word(CMD_PUT,   32'hFFFF_AAAA, 6'd16);
        send_word(CMD_PUT,   32'h0000_5555, 6'd16);
        send_word(CMD_PUT,   32'hFFFF_FFFF, 6'd5);
        send_word(CMD_CLOSE, 32'h0000_0000, 6'd0);
        send_word(CMD_CLOSE, 32'h0000_0000, 6'd0);
        send_word(CMD_PUT,   32'h0000_0000, 6'd31);
        send_word(CMD_PUT,   32'hFFFF_FFFF, 6'd32);
        send_word(CMD_PUT,   32'hA5A5_A5A5, 6'd0);
        send_word(CMD_CLOSE, 32'h1234_5678, 6'd17);
        send_word(CMD_PUT,   32'hCAFE_F00D, 6'd48);
        send_word(CMD_PUT,   32'h8000_0001, 6'd3);
        send_word(CMD_CLOSE, 32'hFFFF_FFFF, 6'd32);
        wait_for_drain();
    endtask

    task automatic test_random_bursts(input int count, input int close_pct);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_random_item(close_pct);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle_cycles(gap);
        end
    endtask

    task automatic test_output_hold_off();
        hold_off_request++;
        repeat (150)
            send_random_item(5);
        wait_for_drain();
    endtask

    task automatic test_drain_pauses();
        repeat (4)
        begin
            test_random_bursts(100, 10);
            wait_for_drain();
        end
    endtask

    // receiver: long hold-off on request, otherwise runs of free flow or random stalls
    always @(negedge clk)
    begin
        if (hold_requests_served != hold_off_request)
        begin
            hold_requests_served = hold_off_request;
            hold_left            = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(4, 48);
                run_free = ($urandom_range(0, 2) == 0);
            end
            run_left--;
            m_tready <= run_free ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk)
    begin
        packed_result_t exp_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("unexpected word %h flush %b", m_tdata, m_tuser));
            else
            begin
                exp_word = pending_words.pop_front();
                if (m_tdata !== exp_word.word)
                    report_mismatch($sformatf("packed word %h, expected %h",
                                              m_tdata, exp_word.word));
                if (m_tuser !== exp_word.flush)
                    report_mismatch($sformatf("flush flag %b, expected %b",
                                              m_tuser, exp_word.flush));
                words_checked++;
                if (exp_word.flush)
                    flush_words++;
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout: %0d words still expected", pending_words.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_bursts(1180, 6);
        test_output_hold_off();
        test_drain_pauses();
        wait_for_drain();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("sent %0d input words (%0d closes) with bursty input and output stalls",
                 words_sent, closes_sent);
        $display("checked %0d packed words (%0d flush), one long output hold, drain pauses",
                 words_checked, flush_words);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
